// File: rtl/core/abp_pkg.sv
// ----------------------------------------------------------------------------
// abp_pkg
// Shared types and constants of the box pair broadphase: widths, op codes,
// object and config records, register indexes and result status codes.
// ----------------------------------------------------------------------------
package abp_pkg;

	// field widths of one object and of the configuration
	localparam int COORD_W   = 32;
	localparam int GROUP_W   = 16;
	localparam int ID_W      = 16;
	localparam int MARGIN_W  = COORD_W - 1;
	localparam int CFG_IDX_W = 2;

	// item operation codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// result status codes
	localparam logic STATUS_PAIR = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALLOW_DISABLED     = 2'd0,
		REG_ALLOW_STATIC_PAIRS = 2'd1,
		REG_GROUP_FILTER_ON    = 2'd2,
		REG_BOX_MARGIN         = 2'd3
	} reg_idx_t;

	// one stored object
	typedef struct packed {
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
		logic                      box_valid;
		logic                      enabled;
		logic                      is_static;
		logic [GROUP_W-1:0]        group;
		logic [ID_W-1:0]           id;
	} obj_t;

	localparam int OBJ_W = $bits(obj_t);

	// pair filter settings
	typedef struct packed {
		logic                allow_disabled;
		logic                allow_static_pairs;
		logic                group_filter_on;
		logic [MARGIN_W-1:0] box_margin;
	} cfg_t;

endpackage

// File: rtl/core/aabb_pair_broadphase.sv
// ----------------------------------------------------------------------------
// aabb_pair_broadphase
// An add with n stored objects scans them one per cycle through the object
// RAM read port and the shared pair test, then drains and flushes the held
// pair; busy stays high until the block is back in idle.
// Clear, full-store and empty-store adds stay in idle and keep busy low.
// Reset empties the store and loads the register reset values; the store RAM
// is not cleared. Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
module aabb_pair_broadphase #(
	parameter int MAX_OBJECTS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 op,
	input  logic signed [abp_pkg::COORD_W-1:0]   min_x,
	input  logic signed [abp_pkg::COORD_W-1:0]   min_y,
	input  logic signed [abp_pkg::COORD_W-1:0]   min_z,
	input  logic signed [abp_pkg::COORD_W-1:0]   max_x,
	input  logic signed [abp_pkg::COORD_W-1:0]   max_y,
	input  logic signed [abp_pkg::COORD_W-1:0]   max_z,
	input  logic                                 box_valid,
	input  logic                                 enabled,
	input  logic                                 is_static,
	input  logic [abp_pkg::GROUP_W-1:0]          group_bits,
	input  logic [abp_pkg::ID_W-1:0]             obj_id,
	// configuration port
	input  logic                                 cfg_we,
	input  logic [abp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [abp_pkg::MARGIN_W-1:0]         cfg_data,
	// result channel
	output logic                                 strobe,
	output logic [abp_pkg::ID_W-1:0]             first_id,
	output logic [abp_pkg::ID_W-1:0]             second_id,
	output logic                                 status,
	output logic                                 last
);
	import abp_pkg::*;

	localparam int ADDR_W = $clog2(MAX_OBJECTS);
	localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FLUSH} state_t;

	state_t            state_q;
	cfg_t              cfg_q;
	obj_t              in_obj;
	obj_t              new_q;
	obj_t              rd_obj;
	logic [OBJ_W-1:0]  rd_data;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] end_q;
	logic              v_s1;
	logic              last_s1;
	logic              pend_q;
	logic [ID_W-1:0]   pend_id_q;
	logic              hit;
	logic              accept;
	logic              full;
	logic              ram_we;
	logic              strobe_q;
	logic [ID_W-1:0]   first_id_q;
	logic [ID_W-1:0]   second_id_q;
	logic              status_q;
	logic              last_q;

	// incoming object
	always_comb begin
		in_obj.min_x     = min_x;
		in_obj.min_y     = min_y;
		in_obj.min_z     = min_z;
		in_obj.max_x     = max_x;
		in_obj.max_y     = max_y;
		in_obj.max_z     = max_z;
		in_obj.box_valid = box_valid;
		in_obj.enabled   = enabled;
		in_obj.is_static = is_static;
		in_obj.group     = group_bits;
		in_obj.id        = obj_id;
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_OBJECTS));
	assign ram_we = accept && (op == OP_ADD) && !full;
	assign rd_obj = obj_t'(rd_data);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.allow_disabled     <= 1'b0;
			cfg_q.allow_static_pairs <= 1'b0;
			cfg_q.group_filter_on    <= 1'b1;
			cfg_q.box_margin         <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ALLOW_DISABLED:     cfg_q.allow_disabled     <= cfg_data[0];
				REG_ALLOW_STATIC_PAIRS: cfg_q.allow_static_pairs <= cfg_data[0];
				REG_GROUP_FILTER_ON:    cfg_q.group_filter_on    <= cfg_data[0];
				REG_BOX_MARGIN:         cfg_q.box_margin         <= cfg_data;
			endcase
		end
	end

	// object store, new object written at its slot when an add is accepted into a store that is not full
	abp_ram #(
		.WIDTH(OBJ_W),
		.DEPTH(MAX_OBJECTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(in_obj),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// shared pair test on the entry read last cycle
	abp_pair_test u_test (
		.stored(rd_obj),
		.fresh (new_q),
		.cfg   (cfg_q),
		.hit   (hit)
	);

	// sequencer, scan pipeline and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			addr_q   <= '0;
			end_q    <= '0;
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			// one-cycle strobe: full status, flushed pair or released pair
			strobe_q <= (accept && (op == OP_ADD) && full)
				|| ((state_q == S_FLUSH) && pend_q)
				|| (v_s1 && hit && pend_q);
			v_s1     <= (state_q == S_SCAN);
			last_s1  <= (state_q == S_SCAN) && (addr_q == end_q);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_q <= in_obj;
						if (op == OP_CLEAR) begin
							count_q <= '0;
						end else if (full) begin
							first_id_q  <= '0;
							second_id_q <= obj_id;
							status_q    <= STATUS_FULL;
							last_q      <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
							if (count_q != '0) begin
								addr_q  <= '0;
								end_q   <= count_q[ADDR_W-1:0] - 1'b1;
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (addr_q == end_q) begin
						state_q <= S_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (v_s1 && last_s1) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					// held pair is the final one of this item
					if (pend_q) begin
						first_id_q  <= pend_id_q;
						second_id_q <= new_q.id;
						status_q    <= STATUS_PAIR;
						last_q      <= 1'b1;
					end
					pend_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
			// a new hit releases the held pair as not last
			if (v_s1 && hit) begin
				if (pend_q) begin
					first_id_q  <= pend_id_q;
					second_id_q <= new_q.id;
					status_q    <= STATUS_PAIR;
					last_q      <= 1'b0;
				end
				pend_q    <= 1'b1;
				pend_id_q <= rd_obj.id;
			end
		end
	end

	assign strobe    = strobe_q;
	assign first_id  = first_id_q;
	assign second_id = second_id_q;
	assign status    = status_q;
	assign last      = last_q;

	// no scan data in flight while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!v_s1 && !pend_q))
		else $error("scan data or held pair left while idle");

	// store count stays within capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_OBJECTS))
		else $error("store count beyond capacity");

	// a full-store status is always the only and final result
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (status_q == STATUS_FULL)) |-> last_q)
		else $error("full status without last");

	// clear empties the store
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_CLEAR)) |=> (count_q == '0))
		else $error("clear did not empty the store");

	// the final pair of a scan only leaves from the flush step
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q && (status_q == STATUS_PAIR)) |-> $past(state_q == S_FLUSH))
		else $error("last pair outside flush");

endmodule

// File: rtl/core/abp_ram.sv
// ----------------------------------------------------------------------------
// abp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module abp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/abp_pair_test.sv
// ----------------------------------------------------------------------------
// abp_pair_test
// Shared pair test unit: applies the pair filters and the three-axis
// overlap test with margin to one stored object and the new object.
// ----------------------------------------------------------------------------
module abp_pair_test (
	input  abp_pkg::obj_t stored,
	input  abp_pkg::obj_t fresh,
	input  abp_pkg::cfg_t cfg,
	output logic          hit
);
	import abp_pkg::*;

	// a.min - m <= b.max + m and b.min - m <= a.max + m, exact in COORD_W+2 bits
	function automatic logic span_hit(
		input logic signed [COORD_W-1:0] amin,
		input logic signed [COORD_W-1:0] amax,
		input logic signed [COORD_W-1:0] bmin,
		input logic signed [COORD_W-1:0] bmax,
		input logic [MARGIN_W-1:0]       m
	);
		logic signed [COORD_W+1:0] lim;
		logic signed [COORD_W+1:0] d_lo;
		logic signed [COORD_W+1:0] d_hi;
		lim  = $signed({2'b00, m, 1'b0});
		d_lo = $signed({{2{amin[COORD_W-1]}}, amin}) - $signed({{2{bmax[COORD_W-1]}}, bmax});
		d_hi = $signed({{2{bmin[COORD_W-1]}}, bmin}) - $signed({{2{amax[COORD_W-1]}}, amax});
		return (d_lo <= lim) && (d_hi <= lim);
	endfunction

	logic both_en;
	logic both_st;
	logic both_ok;
	logic groups_meet;
	logic overlap;

	// flag filters
	assign both_en     = stored.enabled & fresh.enabled;
	assign both_st     = stored.is_static & fresh.is_static;
	assign both_ok     = stored.box_valid & fresh.box_valid;
	assign groups_meet = |(stored.group & fresh.group);

	// overlap on all three axes
	assign overlap = span_hit(stored.min_x, stored.max_x, fresh.min_x, fresh.max_x,
			cfg.box_margin)
		&& span_hit(stored.min_y, stored.max_y, fresh.min_y, fresh.max_y, cfg.box_margin)
		&& span_hit(stored.min_z, stored.max_z, fresh.min_z, fresh.max_z, cfg.box_margin);

	assign hit = (cfg.allow_disabled | both_en)
		& (cfg.allow_static_pairs | ~both_st)
		& (~cfg.group_filter_on | groups_meet)
		& both_ok
		& overlap;

endmodule

// File: verif/tb_aabb_pair_broadphase.sv
// ----------------------------------------------------------------------------
// tb_aabb_pair_broadphase
// Self-checking bench for the box pair broadphase. A behavioral pair tracker
// keeps its own object store and filter settings, and predicts the pair
// results of every accepted item. Results are compared field by field in
// order. Stimulus is a short directed run of filter and overlap corner
// cases, then random clear-and-fill sequences under several filter settings,
// with random sender gaps.
// ----------------------------------------------------------------------------
module tb_aabb_pair_broadphase;
	import abp_pkg::*;

	localparam int MAX_OBJ      = 64;
	localparam int HALF_PERIOD  = 5;
	localparam int ONE          = 1 << 16;
	localparam int SPREAD       = 6 * ONE;
	localparam int SETTLE       = MAX_OBJ + 8;
	localparam int QUIET_LIMIT  = 2000;
	localparam int NUM_PHASES   = 6;
	localparam int PHASE_ITEMS  = 50;
	localparam int PRINT_LIMIT  = 50;

	// one pair or status result
	typedef struct packed {
		logic [ID_W-1:0] first_id;
		logic [ID_W-1:0] second_id;
		logic            status;
		logic            last;
	} pair_result_t;

	// pair tracker: object store, filter settings and pairs still owed
	class pair_tracker;
		obj_t         store[MAX_OBJ];
		int           count;
		cfg_t         cfg;
		pair_result_t pending_pairs[$];
		int           errors;

		function new();
			count = 0;
			errors = 0;
			cfg.allow_disabled = 1'b0;
			cfg.allow_static_pairs = 1'b0;
			cfg.group_filter_on = 1'b1;
			cfg.box_margin = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [MARGIN_W-1:0] data);
			case (idx)
				REG_ALLOW_DISABLED:     cfg.allow_disabled = data[0];
				REG_ALLOW_STATIC_PAIRS: cfg.allow_static_pairs = data[0];
				REG_GROUP_FILTER_ON:    cfg.group_filter_on = data[0];
				default:                cfg.box_margin = data;
			endcase
		endfunction

		function int pending();
			return pending_pairs.size();
		endfunction

		// exact interval test with the margin on both boxes
		function bit span_overlap(logic signed [COORD_W-1:0] amin, amax, bmin, bmax);
			longint m, a0, a1, b0, b1;
			m = cfg.box_margin;
			a0 = amin;
			a1 = amax;
			b0 = bmin;
			b1 = bmax;
			return (a0 - m <= b1 + m) && (a1 + m >= b0 - m);
		endfunction

		// predict the results of one accepted item and update the store
		function void note_item(logic o, obj_t ob);
			pair_result_t r;
			obj_t         s;
			int           hits[$];
			int           i;
			if (o == OP_CLEAR) begin
				count = 0;
				return;
			end
			if (count >= MAX_OBJ) begin
				r.first_id = '0;
				r.second_id = ob.id;
				r.status = STATUS_FULL;
				r.last = 1'b1;
				pending_pairs = {pending_pairs, r};
				return;
			end
			for (i = 0; i < count; i++) begin
				s = store[i];
				if (!cfg.allow_disabled && !(s.enabled && ob.enabled))
					continue;
				if (!cfg.allow_static_pairs && s.is_static && ob.is_static)
					continue;
				if (cfg.group_filter_on && ((s.group & ob.group) == '0))
					continue;
				if (!(s.box_valid && ob.box_valid))
					continue;
				if (!span_overlap(s.min_x, s.max_x, ob.min_x, ob.max_x) ||
					!span_overlap(s.min_y, s.max_y, ob.min_y, ob.max_y) ||
					!span_overlap(s.min_z, s.max_z, ob.min_z, ob.max_z))
					continue;
				hits = {hits, i};
			end
			foreach (hits[k]) begin
				r.first_id = store[hits[k]].id;
				r.second_id = ob.id;
				r.status = STATUS_PAIR;
				r.last = (k == hits.size() - 1);
				pending_pairs = {pending_pairs, r};
			end
			store[count] = ob;
			count++;
		endfunction

		task report_mismatch(string what);
			errors++;
			// keep the log short on a badly broken block
			if (errors <= PRINT_LIMIT)
				$display("%0t mismatch: %s", $time, what);
		endtask

		// compare one result with the oldest owed pair
		task check_pair(logic [ID_W-1:0] f, logic [ID_W-1:0] s, logic st, logic l);
			pair_result_t want;
			if (pending_pairs.size() == 0) begin
				report_mismatch($sformatf("unexpected result first %h second %h status %b last %b",
					f, s, st, l));
				return;
			end
			want = pending_pairs.pop_front();
			if (f !== want.first_id || s !== want.second_id ||
				st !== want.status || l !== want.last)
				report_mismatch($sformatf(
					"got first %h second %h status %b last %b, want %h %h %b %b",
					f, s, st, l, want.first_id, want.second_id, want.status, want.last));
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       op = OP_ADD;
	logic signed [COORD_W-1:0]  min_x = '0;
	logic signed [COORD_W-1:0]  min_y = '0;
	logic signed [COORD_W-1:0]  min_z = '0;
	logic signed [COORD_W-1:0]  max_x = '0;
	logic signed [COORD_W-1:0]  max_y = '0;
	logic signed [COORD_W-1:0]  max_z = '0;
	logic                       box_valid = 1'b0;
	logic                       enabled = 1'b0;
	logic                       is_static = 1'b0;
	logic [GROUP_W-1:0]         group_bits = '0;
	logic [ID_W-1:0]            obj_id = '0;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [MARGIN_W-1:0]        cfg_data = '0;
	logic                       strobe;
	logic [ID_W-1:0]            first_id;
	logic [ID_W-1:0]            second_id;
	logic                       status;
	logic                       last;

	pair_tracker sb;
	obj_t        seen;
	int          quiet_cycles = 0;

	aabb_pair_broadphase #(
		.MAX_OBJECTS(MAX_OBJ)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.min_x(min_x),
		.min_y(min_y),
		.min_z(min_z),
		.max_x(max_x),
		.max_y(max_y),
		.max_z(max_z),
		.box_valid(box_valid),
		.enabled(enabled),
		.is_static(is_static),
		.group_bits(group_bits),
		.obj_id(obj_id),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.first_id(first_id),
		.second_id(second_id),
		.status(status),
		.last(last)
	);

	// clock
	always #(HALF_PERIOD) clk = ~clk;

	// monitor: check results, note accepted items, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe !== 1'b0)
				sb.check_pair(first_id, second_id, status, last);
			if (start && busy === 1'b0) begin
				seen = {min_x, min_y, min_z, max_x, max_y, max_z,
					box_valid, enabled, is_static, group_bits, obj_id};
				sb.note_item(op, seen);
			end
			if (strobe === 1'b1 || (start && busy === 1'b0))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_aabb_pair_broadphase failed");
				$finish;
			end
		end
	end

	// present one item and hold it until the block takes it
	task automatic drive_item(input logic o, input obj_t ob);
		start <= 1'b1;
		op <= o;
		{min_x, min_y, min_z, max_x, max_y, max_z,
			box_valid, enabled, is_static, group_bits, obj_id} <= ob;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// random sender gap, taken now and then when gaps are enabled
	task automatic pause_sender(input bit gaps);
		if (gaps && $urandom_range(0, 9) < 3) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// stop sending, drain owed results, let a silent scan finish
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write all four registers, unused upper bits of the flags randomized
	task automatic write_config(input cfg_t c);
		logic [MARGIN_W-1:0] data;
		int                  i;
		for (i = 0; i <= int'(REG_BOX_MARGIN); i++) begin
			case (reg_idx_t'(i))
				REG_ALLOW_DISABLED:     data = {(MARGIN_W-1)'($urandom), c.allow_disabled};
				REG_ALLOW_STATIC_PAIRS: data = {(MARGIN_W-1)'($urandom), c.allow_static_pairs};
				REG_GROUP_FILTER_ON:    data = {(MARGIN_W-1)'($urandom), c.group_filter_on};
				default:                data = c.box_margin;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data <= data;
			@(posedge clk);
			sb.set_reg(reg_idx_t'(i), data);
		end
		cfg_we <= 1'b0;
	endtask

	// directed object with the same span on every axis
	function automatic obj_t cube(input int lo, input int hi, input bit v, input bit e,
		input bit s, input logic [GROUP_W-1:0] g, input logic [ID_W-1:0] id);
		obj_t ob;
		ob.min_x = lo;
		ob.min_y = lo;
		ob.min_z = lo;
		ob.max_x = hi;
		ob.max_y = hi;
		ob.max_z = hi;
		ob.box_valid = v;
		ob.enabled = e;
		ob.is_static = s;
		ob.group = g;
		ob.id = id;
		return ob;
	endfunction

	function automatic logic signed [COORD_W-1:0] extreme_coord();
		case ($urandom_range(0, 3))
			0:       return {1'b1, {(COORD_W-1){1'b0}}};
			1:       return {1'b0, {(COORD_W-1){1'b1}}};
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	// one axis: mostly clustered spans, some wild and extreme bounds
	function automatic void random_span(input int kind,
		output logic signed [COORD_W-1:0] lo, output logic signed [COORD_W-1:0] hi);
		int                        c, h;
		logic signed [COORD_W-1:0] t;
		if (kind < 20) begin
			c = int'($urandom_range(0, 2 * SPREAD)) - SPREAD;
			h = int'($urandom_range(0, 2 * ONE));
			lo = c - h;
			hi = c + h;
			// inverted box now and then
			if ($urandom_range(0, 15) == 0) begin
				t = lo;
				lo = hi;
				hi = t;
			end
		end else if (kind < 23) begin
			lo = $urandom;
			hi = $urandom;
		end else begin
			lo = extreme_coord();
			hi = extreme_coord();
		end
	endfunction

	function automatic obj_t random_object();
		obj_t ob;
		int   kind;
		kind = $urandom_range(0, 24);
		random_span(kind, ob.min_x, ob.max_x);
		random_span(kind, ob.min_y, ob.max_y);
		random_span(kind, ob.min_z, ob.max_z);
		ob.box_valid = ($urandom_range(0, 9) != 0);
		ob.enabled = ($urandom_range(0, 7) != 0);
		ob.is_static = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 7))
			0:       ob.group = '1;
			1:       ob.group = '0;
			2, 3:    ob.group = GROUP_W'(1) << $urandom_range(0, GROUP_W - 1);
			default: ob.group = GROUP_W'($urandom);
		endcase
		ob.id = ID_W'($urandom);
		return ob;
	endfunction

	// clear, then a run of adds with random content and occasional stray clears
	task automatic run_sequence(input int adds, input bit gaps);
		int k;
		pause_sender(gaps);
		drive_item(OP_CLEAR, random_object());
		for (k = 0; k < adds; k++) begin
			pause_sender(gaps);
			if ($urandom_range(0, 39) == 0)
				drive_item(OP_CLEAR, random_object());
			drive_item(OP_ADD, random_object());
		end
	endtask

	// filter and overlap corner cases under the reset settings
	task automatic directed_items();
		obj_t ob;
		drive_item(OP_CLEAR, cube(-1, -1, 1, 1, 1, '1, '1));
		// empty store, then touching boxes
		drive_item(OP_ADD, cube(0, ONE, 1, 1, 0, 16'h0001, 16'h0001));
		drive_item(OP_ADD, cube(ONE, 2 * ONE, 1, 1, 0, 16'h0003, 16'h0002));
		// disabled member
		drive_item(OP_ADD, cube(0, ONE, 1, 0, 0, '1, 16'h0003));
		// static objects, then a static-static pair
		drive_item(OP_ADD, cube(0, 2 * ONE, 1, 1, 1, 16'h0001, 16'h0004));
		drive_item(OP_ADD, cube(0, ONE, 1, 1, 1, 16'h0001, 16'h0005));
		// disjoint groups, invalid box, inverted box
		drive_item(OP_ADD, cube(0, ONE, 1, 1, 0, 16'h8000, 16'h0006));
		drive_item(OP_ADD, cube(0, ONE, 0, 1, 0, '1, 16'h0007));
		drive_item(OP_ADD, cube(ONE, 0, 1, 1, 0, '1, 16'h0008));
		// just past the upper bound
		drive_item(OP_ADD, cube(2 * ONE + 1, 3 * ONE, 1, 1, 0, '1, 16'h0009));
		// whole coordinate range
		drive_item(OP_ADD, cube(32'h8000_0000, 32'h7fff_ffff, 1, 1, 0, '1, 16'hffff));
		// far positive corner
		drive_item(OP_ADD, cube(32'h7fff_0000, 32'h7fff_ffff, 1, 1, 0, '1, 16'h0000));
		// empty group mask
		drive_item(OP_ADD, cube(0, ONE, 1, 1, 0, 16'h0000, 16'h00aa));
		// overlap on x and y only
		ob = cube(0, ONE, 1, 1, 0, '1, 16'h000b);
		ob.min_z = 5 * ONE;
		ob.max_z = 6 * ONE;
		drive_item(OP_ADD, ob);
		// clear, then an add that finds nothing
		drive_item(OP_CLEAR, cube(0, ONE, 1, 1, 0, '1, 16'h5555));
		drive_item(OP_ADD, cube(0, ONE, 1, 1, 0, '1, 16'h00cc));
	endtask

	// main sequence
	initial begin
		cfg_t settings[NUM_PHASES];
		int   p;
		int   budget;
		int   len;
		bit   gaps;

		sb = new();
		settings[0] = '{1'b0, 1'b0, 1'b1, '0};
		settings[1] = '{1'b1, 1'b1, 1'b0, '1};
		settings[2] = '{1'b1, 1'b0, 1'b1, MARGIN_W'(ONE / 2)};
		settings[3] = '{1'b0, 1'b1, 1'b0, MARGIN_W'($urandom_range(0, 4 * ONE))};
		settings[4] = '{1'($urandom), 1'($urandom), 1'($urandom), MARGIN_W'($urandom)};
		settings[5] = '{1'($urandom), 1'($urandom), 1'($urandom),
			MARGIN_W'($urandom_range(0, ONE))};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_config(settings[p]);
			if (p == 0) begin
				directed_items();
			end else begin
				budget = PHASE_ITEMS;
				while (budget > 0) begin
					// a fill past capacity first in phase 2, otherwise mostly short runs and some long ones
					if (p == 2 && budget == PHASE_ITEMS)
						len = MAX_OBJ + 4;
					else if ($urandom_range(0, 7) == 0)
						len = $urandom_range(MAX_OBJ, MAX_OBJ + 4);
					else
						len = $urandom_range(1, 20);
					// no gaps in the last phase, and some runs without gaps
					gaps = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
					run_sequence(len, gaps);
					budget -= len;
				end
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_aabb_pair_broadphase passed");
		else
			$display("tb_aabb_pair_broadphase failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/abp_pkg.sv
rtl/core/abp_ram.sv
rtl/core/abp_pair_test.sv
rtl/core/aabb_pair_broadphase.sv
verif/tb_aabb_pair_broadphase.sv
